@@ hdl/psp_pkg.sv @@
// Shared constants for the pump schedule and protection controller:
// register indexes, event kinds, report codes and reset values.
// No dependencies.
`default_nettype none

package psp_pkg;

  localparam int TIME_BITS_DEF = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_START   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_STOP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_ENABLED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RUN_MINUTES   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIP_THRESH   = 3'd4;

  localparam int RUN_MIN_W   = 11;
  localparam int THRESH_W    = 8;
  localparam int LIMIT_W     = 17;  // run_minutes * 60 fits in 17 bits

  localparam logic [RUN_MIN_W-1:0] RUN_MIN_RST    = 11'd10;
  localparam logic [THRESH_W-1:0]  TRIP_THRESH_RST = 8'd5;
  localparam logic [LIMIT_W-1:0]   SECS_PER_MIN   = 17'd60;
  localparam logic [THRESH_W-1:0]  OT_COUNT_MAX   = 8'd255;

  // event kinds
  typedef logic [1:0] action_t;
  localparam action_t ACT_SENSOR = 2'd0;
  localparam action_t ACT_BUTTON = 2'd1;
  localparam action_t ACT_TICK   = 2'd2;
  localparam action_t ACT_APP    = 2'd3;

  // report codes
  typedef logic [1:0] report_t;
  localparam report_t REPORT_NONE = 2'd0;
  localparam report_t REPORT_ON   = 2'd1;
  localparam report_t REPORT_OFF  = 2'd2;

endpackage

`default_nettype wire

@@ hdl/pump_schedule_protection_controller.sv @@
// Pump schedule and protection controller, single module.
// Depends on psp_pkg for register indexes, event kinds and report codes.
//
// Usage:
//   Input stream: in_tuser carries the event kind (sensor sample, button,
//   schedule tick, app command); in_tdata carries the time in seconds and
//   the sensor, wanted-state and acknowledge bits. Every input transaction
//   yields exactly one output transaction with the motor drive, trip flag,
//   block end time, runtime and the report code of that event.
//   Configuration: cfg_wr_en writes cfg_wr_data into the register picked by
//   cfg_addr; write only while no event is in flight.
//   Path: an input transaction passes the input register, then the decision logic
//   feeding the result register and the controller state together.
//   Throughput: one event per cycle while out_tready stays high. The state
//   update is one pass of compares and adds; the next event to fire sees it.
//   Stall: while out_tready is low the result register holds and the input
//   register fills; in_tready drops only when both are occupied.
//   Reset (rst_n low, synchronous): motor off, no trip, no block, runtime
//   zero, registers back to start 0, stop 0, schedule off, 10 minutes,
//   threshold 5; both pipeline slots empty.
`default_nettype none

module pump_schedule_protection_controller #(
  parameter int TIME_BITS = psp_pkg::TIME_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata, low bit up: now_time, overtemp_low, desired_on, app_ack, zero fill
  input  wire logic [((TIME_BITS+3+7)/8)*8-1:0]    in_tdata,
  // tuser: action
  input  wire psp_pkg::action_t                    in_tuser,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tdata, low bit up: motor_on, trip_flag, block_until, run_seconds,
  // report_code, zero fill
  output logic [((2*TIME_BITS+4+7)/8)*8-1:0]       out_tdata,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [psp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [TIME_BITS-1:0]                cfg_wr_data
);
  import psp_pkg::*;

  localparam int OUT_W  = ((2 * TIME_BITS + 4 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (2 * TIME_BITS + 4);

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration registers
  time_t                 sched_start_r;
  time_t                 sched_stop_r;
  logic                  sched_en_r;
  logic [RUN_MIN_W-1:0]  run_min_r;
  logic [THRESH_W-1:0]   trip_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_start_r <= '0;
      sched_stop_r  <= '0;
      sched_en_r    <= 1'b0;
      run_min_r     <= RUN_MIN_RST;
      trip_thr_r    <= TRIP_THRESH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SCHED_START:   sched_start_r <= cfg_wr_data;
        REG_SCHED_STOP:    sched_stop_r  <= cfg_wr_data;
        REG_SCHED_ENABLED: sched_en_r    <= cfg_wr_data[0];
        REG_RUN_MINUTES:   run_min_r     <= cfg_wr_data[RUN_MIN_W-1:0];
        REG_TRIP_THRESH:   trip_thr_r    <= cfg_wr_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    in_vld_r;
  logic    out_vld_r;
  logic    out_free;
  logic    fire;

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // input register
  action_t act_r;
  time_t   now_r;
  logic    ot_low_r;
  logic    want_on_r;
  logic    ack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r     <= in_tuser;
      now_r     <= in_tdata[TIME_BITS-1:0];
      ot_low_r  <= in_tdata[TIME_BITS];
      want_on_r <= in_tdata[TIME_BITS+1];
      ack_r     <= in_tdata[TIME_BITS+2];
    end
  end

  // controller state
  logic                motor_r,  motor_nxt;
  logic                window_r, window_nxt;
  logic                trip_r,   trip_nxt;
  time_t               block_r,  block_nxt;
  logic [THRESH_W-1:0] ot_cnt_r, ot_cnt_nxt;
  time_t               start_r,  start_nxt;
  time_t               rt_r,     rt_nxt;
  report_t             report_nxt;

  logic [LIMIT_W-1:0]  limit_s;
  time_t               limit_t;
  time_t               fallback;
  time_t               elapsed;
  logic [THRESH_W-1:0] ot_inc;
  logic                sched_go;

  assign limit_s  = LIMIT_W'(run_min_r) * SECS_PER_MIN;
  assign limit_t  = TIME_BITS'(limit_s);
  assign fallback = (sched_stop_r != '0) ? sched_stop_r : now_r + limit_t;
  assign elapsed  = now_r - start_r;
  assign ot_inc   = (ot_cnt_r == OT_COUNT_MAX) ? ot_cnt_r : ot_cnt_r + 1'b1;

  always_comb begin
    motor_nxt  = motor_r;
    window_nxt = window_r;
    trip_nxt   = trip_r;
    block_nxt  = block_r;
    ot_cnt_nxt = ot_cnt_r;
    start_nxt  = start_r;
    rt_nxt     = rt_r;
    report_nxt = REPORT_NONE;
    sched_go   = 1'b0;

    case (act_r)
      ACT_SENSOR: begin
        if (!motor_r || !ot_low_r) begin
          ot_cnt_nxt = '0;
        end else if (ot_inc >= trip_thr_r) begin
          motor_nxt  = 1'b0;
          window_nxt = 1'b0;
          block_nxt  = fallback;
          trip_nxt   = 1'b1;
          ot_cnt_nxt = '0;
          report_nxt = REPORT_OFF;
        end else begin
          ot_cnt_nxt = ot_inc;
        end
      end
      ACT_BUTTON: begin
        if (trip_r) begin
          trip_nxt  = 1'b0;
          block_nxt = '0;
        end else if (motor_r) begin
          motor_nxt  = 1'b0;
          window_nxt = 1'b0;
          block_nxt  = fallback;
          report_nxt = REPORT_OFF;
        end else begin
          motor_nxt  = 1'b1;
          start_nxt  = now_r;
          rt_nxt     = '0;
          block_nxt  = '0;
          report_nxt = REPORT_ON;
        end
      end
      ACT_TICK: begin
        // runtime limit first, then block expiry, scheduled start, window end
        if (motor_r) begin
          rt_nxt = elapsed;
          if (elapsed >= limit_t) begin
            motor_nxt  = 1'b0;
            window_nxt = 1'b0;
            rt_nxt     = '0;
            report_nxt = REPORT_OFF;
          end
        end
        if (block_r != '0 && now_r >= block_r) begin
          block_nxt = '0;
        end
        sched_go = !window_nxt && now_r >= sched_start_r && now_r < sched_stop_r
                   && sched_en_r && !(block_nxt != '0 && now_r < block_nxt)
                   && !trip_r;
        if (sched_go) begin
          motor_nxt  = 1'b1;
          start_nxt  = now_r;
          rt_nxt     = '0;
          window_nxt = 1'b1;
          report_nxt = REPORT_ON;
        end
        if (window_nxt && now_r >= sched_stop_r) begin
          motor_nxt  = 1'b0;
          window_nxt = 1'b0;
          report_nxt = REPORT_OFF;
        end
      end
      default: begin
        if (ack_r && want_on_r && !trip_r && !motor_r) begin
          motor_nxt  = 1'b1;
          start_nxt  = now_r;
          rt_nxt     = '0;
          block_nxt  = '0;
          report_nxt = REPORT_ON;
        end else if (ack_r && !want_on_r && motor_r) begin
          motor_nxt  = 1'b0;
          window_nxt = 1'b0;
          block_nxt  = fallback;
          report_nxt = REPORT_OFF;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_r  <= 1'b0;
      window_r <= 1'b0;
      trip_r   <= 1'b0;
      block_r  <= '0;
      ot_cnt_r <= '0;
      start_r  <= '0;
      rt_r     <= '0;
    end else if (fire) begin
      motor_r  <= motor_nxt;
      window_r <= window_nxt;
      trip_r   <= trip_nxt;
      block_r  <= block_nxt;
      ot_cnt_r <= ot_cnt_nxt;
      start_r  <= start_nxt;
      rt_r     <= rt_nxt;
    end
  end

  // result register
  report_t report_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      report_r <= report_nxt;
    end
  end

  // state registers double as the result payload: they change only on fire
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, report_r, rt_r, block_r, trip_r, motor_r};

  // checks
  a_trip_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
    trip_r |-> !motor_r)
    else $error("motor running while tripped");

  a_window_motor_on: assert property (@(posedge clk) disable iff (!rst_n)
    window_r |-> motor_r)
    else $error("schedule window open with motor off");

  a_report_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (report_r == REPORT_NONE || report_r == REPORT_ON ||
                   report_r == REPORT_OFF))
    else $error("illegal report code");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("transaction lost between input and result register");

endmodule

`default_nettype wire

@@ bench/tb_pump_schedule_protection_controller.sv @@
// Testbench for the pump schedule and protection controller.
// Drives random and directed events under several register settings and
// checks every result against an in-bench predictor. Depends on psp_pkg.
`default_nettype none

module tb_pump_schedule_protection_controller;
  import psp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    bit          motor_on;
    bit          trip_flag;
    logic [31:0] block_until;
    logic [31:0] run_seconds;
    report_t     report_code;
  } pump_status_t;

  // Predicts the controller state after each event and checks results in order
  class pump_scoreboard;
    logic [31:0] win_start, win_stop;
    bit          sched_en;
    logic [10:0] run_min;
    logic [7:0]  trip_thr;
    bit          motor, window_on, tripped;
    logic [31:0] block_end, started_at, runtime;
    logic [7:0]  ot_count;
    pump_status_t expected_status[$];
    int errors;

    function new();
      win_start = '0;
      win_stop = '0;
      sched_en = 1'b0;
      run_min = RUN_MIN_RST;
      trip_thr = TRIP_THRESH_RST;
      motor = 1'b0;
      window_on = 1'b0;
      tripped = 1'b0;
      block_end = '0;
      started_at = '0;
      runtime = '0;
      ot_count = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
      case (addr)
        REG_SCHED_START:   win_start = data;
        REG_SCHED_STOP:    win_stop = data;
        REG_SCHED_ENABLED: sched_en = data[0];
        REG_RUN_MINUTES:   run_min = data[10:0];
        REG_TRIP_THRESH:   trip_thr = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] run_limit();
      return {21'b0, run_min} * 32'd60;
    endfunction

    function void start_motor(logic [31:0] now);
      motor = 1'b1;
      started_at = now;
      runtime = '0;
    endfunction

    // block ends at the window end, or now plus the run length if no window end
    function void stop_and_block(logic [31:0] now);
      motor = 1'b0;
      window_on = 1'b0;
      block_end = (win_stop != 0) ? win_stop : now + run_limit();
    endfunction

    function void note_event(action_t act, logic [31:0] now, bit ot_low, bit want_on,
                             bit ack);
      report_t      rep;
      pump_status_t st;
      rep = REPORT_NONE;
      case (act)
        ACT_SENSOR: begin
          if (!motor || !ot_low) begin
            ot_count = '0;
          end else begin
            if (ot_count != OT_COUNT_MAX) ot_count++;
            if (ot_count >= trip_thr) begin
              stop_and_block(now);
              tripped = 1'b1;
              ot_count = '0;
              rep = REPORT_OFF;
            end
          end
        end
        ACT_BUTTON: begin
          if (tripped) begin
            tripped = 1'b0;
            block_end = '0;
          end else if (motor) begin
            stop_and_block(now);
            rep = REPORT_OFF;
          end else begin
            start_motor(now);
            block_end = '0;
            rep = REPORT_ON;
          end
        end
        ACT_TICK: begin
          if (motor) begin
            runtime = now - started_at;
            if (runtime >= run_limit()) begin
              motor = 1'b0;
              window_on = 1'b0;
              runtime = '0;
              rep = REPORT_OFF;
            end
          end
          if (block_end != 0 && now >= block_end) block_end = '0;
          if (!window_on && now >= win_start && now < win_stop && sched_en &&
              !(block_end != 0 && now < block_end) && !tripped) begin
            start_motor(now);
            window_on = 1'b1;
            rep = REPORT_ON;
          end
          if (window_on && now >= win_stop) begin
            motor = 1'b0;
            window_on = 1'b0;
            rep = REPORT_OFF;
          end
        end
        default: begin
          if (ack && want_on && !tripped && !motor) begin
            start_motor(now);
            block_end = '0;
            rep = REPORT_ON;
          end else if (ack && !want_on && motor) begin
            stop_and_block(now);
            rep = REPORT_OFF;
          end
        end
      endcase
      st.motor_on = motor;
      st.trip_flag = tripped;
      st.block_until = block_end;
      st.run_seconds = runtime;
      st.report_code = rep;
      expected_status.push_back(st);
    endfunction

    function void check_status(logic [71:0] data);
      pump_status_t e;
      if (expected_status.size() == 0) begin
        $error("result transaction with nothing expected: %0h", data);
        errors++;
        return;
      end
      e = expected_status.pop_front();
      if (data[0] !== e.motor_on) begin
        $error("motor_on: expected %0d, got %0d", e.motor_on, data[0]);
        errors++;
      end
      if (data[1] !== e.trip_flag) begin
        $error("trip_flag: expected %0d, got %0d", e.trip_flag, data[1]);
        errors++;
      end
      if (data[33:2] !== e.block_until) begin
        $error("block_until: expected %0h, got %0h", e.block_until, data[33:2]);
        errors++;
      end
      if (data[65:34] !== e.run_seconds) begin
        $error("run_seconds: expected %0h, got %0h", e.run_seconds, data[65:34]);
        errors++;
      end
      if (data[67:66] !== e.report_code) begin
        $error("report_code: expected %0d, got %0d", e.report_code, data[67:66]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  // now_time, overtemp_low, desired_on, app_ack, zero fill
  logic [39:0]           in_tdata = '0;
  // action
  action_t               in_tuser = ACT_SENSOR;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  // motor_on, trip_flag, block_until, run_seconds, report_code, zero fill
  wire  [71:0]           out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]           cfg_wr_data = '0;

  pump_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycles = 0;
  logic [31:0]    clock_s = 32'd5000;

  pump_schedule_protection_controller uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) sb.write_reg(cfg_addr, cfg_wr_data);
    if (rst_n && in_tvalid && in_tready)
      sb.note_event(in_tuser, in_tdata[31:0], in_tdata[32], in_tdata[33], in_tdata[34]);
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_pump_schedule_protection_controller: done, errors");
      $finish;
    end
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // valid stays high after acceptance; the next call or an idle cycle moves it
  task automatic send_event(input action_t act, input logic [31:0] now, input bit ot,
                            input bit want, input bit ack);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'b0, ack, want, ot, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly a steadily advancing clock, with the odd wild or backward time
  task automatic send_random_event();
    int unsigned r;
    logic [31:0] now;
    action_t     act;
    r = $urandom_range(99);
    if (r < 4) begin
      now = $urandom();
    end else if (r < 7) begin
      now = clock_s - $urandom_range(500);
    end else begin
      clock_s = clock_s + $urandom_range(90);
      now = clock_s;
    end
    r = $urandom_range(99);
    act = (r < 30) ? ACT_SENSOR : (r < 45) ? ACT_BUTTON : (r < 80) ? ACT_TICK : ACT_APP;
    send_event(act, now, $urandom_range(99) < 85, 1'($urandom_range(1)),
               $urandom_range(99) < 80);
  endtask

  // hold the sender off until every result is back and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] ws, input logic [31:0] wp, input bit en,
                            input logic [10:0] mins, input logic [7:0] thr);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= REG_SCHED_START;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_addr    <= REG_SCHED_STOP;
    cfg_wr_data <= wp;
    @(posedge clk);
    cfg_addr    <= REG_SCHED_ENABLED;
    cfg_wr_data <= {31'b0, en};
    @(posedge clk);
    cfg_addr    <= REG_RUN_MINUTES;
    cfg_wr_data <= {21'b0, mins};
    @(posedge clk);
    cfg_addr    <= REG_TRIP_THRESH;
    cfg_wr_data <= {24'b0, thr};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [31:0] ws;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings (10 minutes, threshold 5, schedule off)
    set_idling(3);
    send_event(ACT_TICK,   32'h0000_0000, 1'b0, 1'b0, 1'b0);
    send_event(ACT_APP,    32'h0000_0010, 1'b1, 1'b1, 1'b0);  // no ack
    send_event(ACT_APP,    32'hFFFF_FF00, 1'b0, 1'b1, 1'b1);  // on
    send_event(ACT_APP,    32'hFFFF_FF10, 1'b0, 1'b1, 1'b1);  // already on
    send_event(ACT_TICK,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_event(ACT_TICK,   32'h0000_0200, 1'b0, 1'b0, 1'b0);  // runtime wraps past limit
    send_event(ACT_BUTTON, 32'd100,       1'b0, 1'b0, 1'b0);  // on
    send_event(ACT_BUTTON, 32'd120,       1'b1, 1'b1, 1'b1);  // off with block
    send_event(ACT_TICK,   32'd720,       1'b0, 1'b0, 1'b0);  // block expires
    send_event(ACT_BUTTON, 32'd1000,      1'b0, 1'b0, 1'b0);
    send_event(ACT_SENSOR, 32'd1001,      1'b0, 1'b0, 1'b0);
    repeat (5) send_event(ACT_SENSOR, 32'd1002, 1'b1, 1'b0, 1'b0);  // trips on fifth
    send_event(ACT_APP,    32'd1010,      1'b0, 1'b1, 1'b1);  // on refused while tripped
    send_event(ACT_BUTTON, 32'd1020,      1'b0, 1'b0, 1'b0);  // clears trip only
    send_event(ACT_SENSOR, 32'd1030,      1'b1, 1'b0, 1'b0);  // motor off, no count
    send_event(ACT_APP,    32'd1040,      1'b0, 1'b0, 1'b1);  // off while off
    send_event(ACT_APP,    32'd1050,      1'b0, 1'b1, 1'b1);
    send_event(ACT_APP,    32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1);  // block wraps
    send_event(ACT_TICK,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);

    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg)
        0: write_regs(clock_s, clock_s + 3000, 1'b1, 11'd1, 8'd3);
        1: write_regs(32'd0, 32'd0, 1'b1, 11'd10, 8'd1);
        2: write_regs(clock_s + 200, clock_s + 2500, 1'b1, 11'd0, 8'd2);
        3: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 11'd1440, 8'd255);
        4: write_regs(clock_s, clock_s + 4000, 1'b1, 11'd2, 8'd0);
        default: begin
          ws = clock_s + $urandom_range(1000);
          write_regs(ws, ($urandom_range(3) == 0) ? 32'd0 : ws + $urandom_range(1, 4000),
                     1'($urandom_range(1)),
                     ($urandom_range(9) == 0) ? 11'd1440 : 11'($urandom_range(30)),
                     8'($urandom_range(1, 8)));
        end
      endcase
      set_idling(seg % 4);
      if (seg == 3) begin
        // state is settled here; get the motor running, then a long run of lows
        if (!sb.motor) begin
          if (sb.tripped) send_event(ACT_BUTTON, clock_s, 1'b0, 1'b0, 1'b0);
          send_event(ACT_BUTTON, clock_s, 1'b0, 1'b0, 1'b0);
        end
        repeat (256)
          send_event(ACT_SENSOR, clock_s, 1'b1, 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      end
      repeat (34) send_random_event();
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_pump_schedule_protection_controller: done, clean");
    end else begin
      $display("tb_pump_schedule_protection_controller: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/psp_pkg.sv
hdl/pump_schedule_protection_controller.sv
bench/tb_pump_schedule_protection_controller.sv
